// File: rtl/core/asrq_pkg.sv
// ----------------------------------------------------------------------------
// asrq_pkg
// Shared types and constants for the aged sequence ring queue.
// ----------------------------------------------------------------------------
package asrq_pkg;

    localparam int CAPACITY_DEF = 4;
    localparam logic [15:0] AGE_LIMIT_RST = 16'd3;
    localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_PUBLISH = 2'd1,
        CMD_READ    = 2'd2,
        CMD_CLEAN   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_TICK         = 4'd0,
        ST_ACCEPTED     = 4'd1,
        ST_FULL         = 4'd2,
        ST_EXHAUSTED    = 4'd3,
        ST_EXACT        = 4'd4,
        ST_SKIPPED      = 4'd5,
        ST_NOT_FOUND    = 4'd6,
        ST_REMOVED      = 4'd7,
        ST_NONE_REMOVED = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } fsm_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] stamp;
        logic [15:0] pub_id;
        logic [31:0] payload;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        status_t     status;
        logic [31:0] seq;
        logic [15:0] pub_id;
        logic [31:0] payload;
        logic [31:0] stamp;
    } result_t;

endpackage

// File: rtl/core/asrq_req_if.sv
// ----------------------------------------------------------------------------
// asrq_req_if
// Command channel: valid/ready handshake carrying one queue command.
// ----------------------------------------------------------------------------
interface asrq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] pub_id;
    logic [31:0] payload;
    logic [31:0] last_seq;

    modport source (output valid, output cmd, output pub_id, output payload,
                    output last_seq, input ready);
    modport sink   (input valid, input cmd, input pub_id, input payload,
                    input last_seq, output ready);
endinterface

// File: rtl/core/asrq_rsp_if.sv
// ----------------------------------------------------------------------------
// asrq_rsp_if
// Result channel: valid/ready handshake carrying one command result.
// ----------------------------------------------------------------------------
interface asrq_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] out_seq;
    logic [15:0] out_pub_id;
    logic [31:0] out_payload;
    logic [31:0] out_stamp;

    modport source (output valid, output status, output out_seq, output out_pub_id,
                    output out_payload, output out_stamp, input ready);
    modport sink   (input valid, input status, input out_seq, input out_pub_id,
                    input out_payload, input out_stamp, output ready);
endinterface

// File: rtl/core/asrq_ram.sv
// ----------------------------------------------------------------------------
// asrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/aged_sequence_ring_queue.sv
// ----------------------------------------------------------------------------
// aged_sequence_ring_queue
// Bounded FIFO of sequence-stamped entries with read-next and age eviction.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives one result transaction. Tick and
// publish go from accept straight to the emit state. Read examines entries from
// the oldest until one has a sequence number above last_seq or all are examined;
// clean evicts entries from the oldest while their age reaches the age limit and
// stops at the first younger entry or when the queue empties. Read or clean on
// an empty queue goes straight to emit. The result register is loaded as emit
// returns to idle. Read and clean walk the entry RAM one entry per cycle through
// its single registered read port. The result register lets the next command be
// accepted while a result still waits to be taken; that command then holds in
// its emit state until the waiting result is taken. The entry RAM needs no
// clearing pass; only entries inside the fill are read.
module aged_sequence_ring_queue
#(
    parameter int CAPACITY = asrq_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    asrq_req_if.sink    req,
    asrq_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    import asrq_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] SUM_CAP  = SUM_W'(CAPACITY);

    fsm_t              state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [31:0]       last_seq_reg, last_seq_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [PTR_W-1:0]  oldest_reg, oldest_next;
    logic [31:0]       seq_reg, seq_next;
    logic [31:0]       now_reg, now_next;
    logic [15:0]       age_limit_reg, age_limit_next;
    logic [PTR_W-1:0]  scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              removed_reg, removed_next;
    result_t           res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [PTR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    entry_t             rd_entry;
    entry_t             wr_entry;
    logic [SUM_W-1:0]   pub_sum;
    logic [PTR_W-1:0]   pub_slot;
    logic [PTR_W-1:0]   scan_nxt;
    logic [32:0]        target;
    logic [31:0]        age;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    asrq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);
    assign pub_sum  = SUM_W'(oldest_reg) + SUM_W'(fill_reg);
    assign pub_slot = (pub_sum >= SUM_CAP) ? PTR_W'(pub_sum - SUM_CAP) : PTR_W'(pub_sum);
    assign scan_nxt = wrap_inc(scan_ptr_reg);
    // last_seq of all ones targets 2^32, beyond any stored number
    assign target   = {1'b0, last_seq_reg} + 33'd1;
    assign age      = now_reg - rd_entry.stamp;

    always_comb
    begin
        wr_entry.seq     = seq_reg + 32'd1;
        wr_entry.stamp   = now_reg;
        wr_entry.pub_id  = req.pub_id;
        wr_entry.payload = req.payload;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        last_seq_next  = last_seq_reg;
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        seq_next       = seq_reg;
        now_next       = now_reg;
        age_limit_next = cfg_we ? cfg_wdata : age_limit_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_idx_next  = scan_idx_reg;
        removed_next   = removed_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        req.ready      = (state_reg == S_IDLE);
        ram_we         = 1'b0;
        ram_waddr      = pub_slot;
        ram_wdata      = wr_entry;
        ram_raddr      = oldest_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next      = cmd_t'(req.cmd);
                    last_seq_next = req.last_seq;
                    scan_ptr_next = oldest_reg;
                    scan_idx_next = '0;
                    removed_next  = 1'b0;
                    res_next      = '0;
                    state_next    = S_EMIT;
                    unique case (cmd_t'(req.cmd))
                        CMD_TICK:
                        begin
                            now_next        = now_reg + 32'd1;
                            res_next.status = ST_TICK;
                        end
                        CMD_PUBLISH:
                        begin
                            priority if (fill_reg >= CNT_CAP)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else if (seq_reg == SEQ_MAX)
                            begin
                                res_next.status = ST_EXHAUSTED;
                            end
                            else
                            begin
                                ram_we           = 1'b1;
                                seq_next         = wr_entry.seq;
                                fill_next        = fill_reg + CNT_W'(1);
                                res_next.status  = ST_ACCEPTED;
                                res_next.seq     = wr_entry.seq;
                                res_next.pub_id  = wr_entry.pub_id;
                                res_next.payload = wr_entry.payload;
                                res_next.stamp   = wr_entry.stamp;
                            end
                        end
                        CMD_READ:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_next.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_CLEAN:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_next.status = ST_NONE_REMOVED;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // ram_rdata holds the entry at scan_ptr_reg
                if (cmd_reg == CMD_READ)
                begin
                    if ({1'b0, rd_entry.seq} >= target)
                    begin
                        res_next.status  = ({1'b0, rd_entry.seq} == target) ? ST_EXACT
                                                                            : ST_SKIPPED;
                        res_next.seq     = rd_entry.seq;
                        res_next.pub_id  = rd_entry.pub_id;
                        res_next.payload = rd_entry.payload;
                        res_next.stamp   = rd_entry.stamp;
                        state_next       = S_EMIT;
                    end
                    else if (scan_idx_reg + CNT_W'(1) == fill_reg)
                    begin
                        res_next.status = ST_NOT_FOUND;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        scan_ptr_next = scan_nxt;
                        scan_idx_next = scan_idx_reg + CNT_W'(1);
                        ram_raddr     = scan_nxt;
                    end
                end
                else
                begin
                    if (age >= {16'd0, age_limit_reg})
                    begin
                        oldest_next  = scan_nxt;
                        fill_next    = fill_reg - CNT_W'(1);
                        removed_next = 1'b1;
                        if (fill_reg == CNT_W'(1))
                        begin
                            res_next.status = ST_REMOVED;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            scan_ptr_next = scan_nxt;
                            ram_raddr     = scan_nxt;
                        end
                    end
                    else
                    begin
                        res_next.status = removed_reg ? ST_REMOVED : ST_NONE_REMOVED;
                        state_next      = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            seq_reg       <= '0;
            now_reg       <= '0;
            age_limit_reg <= AGE_LIMIT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            seq_reg       <= seq_next;
            now_reg       <= now_next;
            age_limit_reg <= age_limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        last_seq_reg <= last_seq_next;
        scan_ptr_reg <= scan_ptr_next;
        scan_idx_reg <= scan_idx_next;
        removed_reg  <= removed_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.out_seq     = out_reg.seq;
    assign rsp.out_pub_id  = out_reg.pub_id;
    assign rsp.out_payload = out_reg.payload;
    assign rsp.out_stamp   = out_reg.stamp;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_CAP)
        else $error("fill count exceeds capacity");

    a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oldest_reg <= PTR_LAST)
        else $error("oldest pointer out of range");

    a_scan_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_idx_reg < fill_reg))
        else $error("scan beyond the filled entries");

    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (seq_reg == $past(seq_reg) || seq_reg == $past(seq_reg) + 32'd1))
        else $error("sequence counter jumped");
`endif

endmodule
